// ===== hdl/spd_pkg.sv =====
// Package for the status packet deframer: constants, types and the CRC-16 byte update.
package spd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0]  HDR_SYNC  = 8'hFF;
  localparam logic [7:0]  HDR_THIRD = 8'hFD;
  localparam logic [7:0]  HDR_FOURTH = 8'h00;
  localparam logic [15:0] CRC_POLY  = 16'h8005;
  localparam logic [15:0] CRC_MSB   = 16'h8000;
  localparam logic [15:0] LEN_MIN   = 16'd3;

  typedef enum logic [2:0] {
    RC_OK      = 3'd0,
    RC_HEADER  = 3'd1,
    RC_SHORT   = 3'd2,
    RC_CRC     = 3'd3,
    RC_TIMEOUT = 3'd4
  } rc_t;

  typedef enum logic [10:0] {
    PH_HUNT  = 11'b00000000001,
    PH_HDR2  = 11'b00000000010,
    PH_HDR3  = 11'b00000000100,
    PH_HDR4  = 11'b00000001000,
    PH_ID    = 11'b00000010000,
    PH_LENL  = 11'b00000100000,
    PH_LENH  = 11'b00001000000,
    PH_INST  = 11'b00010000000,
    PH_PARAM = 11'b00100000000,
    PH_CRCL  = 11'b01000000000,
    PH_CRCH  = 11'b10000000000
  } phase_t;

  // classified input word
  typedef struct packed {
    logic       timeout;
    logic [7:0] b;
    logic       is_sync;
    logic       is_third;
    logic       is_fourth;
  } tok_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/spd_if.sv =====
// Valid/ready channel interfaces for the deframer input and result words.
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface spd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] servo_id;
  logic [7:0] instruction;
  logic [7:0] error_byte;
  logic [2:0] result_code;
  logic       last;

  modport source (output valid, output data_byte, output servo_id, output instruction,
                  output error_byte, output result_code, output last, input ready);
  modport sink   (input valid, input data_byte, input servo_id, input instruction,
                  input error_byte, input result_code, input last, output ready);
endinterface

// ===== hdl/spd_front.sv =====
// Front end: accepts input words and classifies them into queue tokens.
module spd_front
  import spd_pkg::*;
(
  spd_in_if.sink in_ch,
  input  logic   push_ready,
  output logic   push_valid,
  output tok_t   push_tok
);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_tok.timeout   = in_ch.op;
    push_tok.b         = in_ch.rx_byte;
    push_tok.is_sync   = (in_ch.rx_byte == HDR_SYNC);
    push_tok.is_third  = (in_ch.rx_byte == HDR_THIRD);
    push_tok.is_fourth = (in_ch.rx_byte == HDR_FOURTH);
  end

endmodule

// ===== hdl/spd_queue.sv =====
// Short token queue between the front end and the parser.
module spd_queue
  import spd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  tok_t push_tok,
  output logic push_ready,
  output logic pop_valid,
  output tok_t pop_tok,
  input  logic pop
);

  tok_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ===== hdl/spd_back.sv =====
// Back end: packet parser state machine, CRC check and output register.
module spd_back
  import spd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tok_valid,
  input  tok_t       tok,
  output logic       pop,
  spd_out_if.source  out_ch
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] param_cnt_r, param_cnt_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  inst_r, inst_nxt;
  logic [7:0]  err_r, err_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic        ovld_r, ovld_nxt;
  logic [7:0]  o_data_r, o_data_nxt;
  logic [7:0]  o_id_r, o_id_nxt;
  logic [7:0]  o_inst_r, o_inst_nxt;
  logic [7:0]  o_err_r, o_err_nxt;
  rc_t         o_rc_r, o_rc_nxt;
  logic        o_last_r, o_last_nxt;

  logic        vflag;
  rc_t         vcode;
  logic [15:0] crc_upd;
  logic [15:0] cnt_inc;

  assign pop     = tok_valid && (!ovld_r || out_ch.ready);
  assign crc_upd = crc_byte(crc_r, tok.b);
  assign cnt_inc = param_cnt_r + 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    crc_nxt       = crc_r;
    frame_len_nxt = frame_len_r;
    param_cnt_nxt = param_cnt_r;
    id_nxt        = id_r;
    inst_nxt      = inst_r;
    err_nxt       = err_r;
    len_lo_nxt    = len_lo_r;
    crc_lo_nxt    = crc_lo_r;
    ovld_nxt      = ovld_r && !out_ch.ready;
    o_data_nxt    = o_data_r;
    o_id_nxt      = o_id_r;
    o_inst_nxt    = o_inst_r;
    o_err_nxt     = o_err_r;
    o_rc_nxt      = o_rc_r;
    o_last_nxt    = o_last_r;
    vflag         = 1'b0;
    vcode         = RC_OK;

    if (pop) begin
      if (tok.timeout) begin
        vflag = 1'b1;
        vcode = RC_TIMEOUT;
      end else begin
        unique case (phase_r)
          PH_HDR2: begin
            if (!tok.is_sync) begin
              vflag = 1'b1;
              vcode = RC_HEADER;
            end else begin
              crc_nxt   = crc_upd;
              phase_nxt = PH_HDR3;
            end
          end
          PH_HDR3: begin
            if (!tok.is_third) begin
              vflag = 1'b1;
              vcode = RC_HEADER;
            end else begin
              crc_nxt   = crc_upd;
              phase_nxt = PH_HDR4;
            end
          end
          PH_HDR4: begin
            if (!tok.is_fourth) begin
              vflag = 1'b1;
              vcode = RC_HEADER;
            end else begin
              crc_nxt   = crc_upd;
              phase_nxt = PH_ID;
            end
          end
          PH_ID: begin
            id_nxt    = tok.b;
            crc_nxt   = crc_upd;
            phase_nxt = PH_LENL;
          end
          PH_LENL: begin
            len_lo_nxt = tok.b;
            crc_nxt    = crc_upd;
            phase_nxt  = PH_LENH;
          end
          PH_LENH: begin
            frame_len_nxt = {tok.b, len_lo_r};
            crc_nxt       = crc_upd;
            phase_nxt     = PH_INST;
          end
          PH_INST: begin
            inst_nxt = tok.b;
            crc_nxt  = crc_upd;
            if (frame_len_r < LEN_MIN) begin
              vflag = 1'b1;
              vcode = RC_SHORT;
            end else begin
              param_cnt_nxt = '0;
              phase_nxt     = (frame_len_r == LEN_MIN) ? PH_CRCL : PH_PARAM;
            end
          end
          PH_PARAM: begin
            crc_nxt = crc_upd;
            if (param_cnt_r == '0) begin
              err_nxt = tok.b;
            end else begin
              ovld_nxt   = 1'b1;
              o_data_nxt = tok.b;
              o_id_nxt   = '0;
              o_inst_nxt = '0;
              o_err_nxt  = '0;
              o_rc_nxt   = RC_OK;
              o_last_nxt = 1'b0;
            end
            param_cnt_nxt = cnt_inc;
            if (cnt_inc >= frame_len_r - LEN_MIN) begin
              phase_nxt = PH_CRCL;
            end
          end
          PH_CRCL: begin
            crc_lo_nxt = tok.b;
            phase_nxt  = PH_CRCH;
          end
          PH_CRCH: begin
            vflag = 1'b1;
            vcode = ({tok.b, crc_lo_r} == crc_r) ? RC_OK : RC_CRC;
          end
          PH_HUNT: begin
            if (tok.is_sync) begin
              crc_nxt   = crc_byte(16'h0000, tok.b);
              phase_nxt = PH_HDR2;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end

      if (vflag) begin
        ovld_nxt      = 1'b1;
        o_data_nxt    = '0;
        o_id_nxt      = id_nxt;
        o_inst_nxt    = inst_nxt;
        o_err_nxt     = err_nxt;
        o_rc_nxt      = vcode;
        o_last_nxt    = 1'b1;
        phase_nxt     = PH_HUNT;
        crc_nxt       = '0;
        frame_len_nxt = '0;
        param_cnt_nxt = '0;
        id_nxt        = '0;
        inst_nxt      = '0;
        err_nxt       = '0;
        len_lo_nxt    = '0;
        crc_lo_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      crc_r       <= '0;
      frame_len_r <= '0;
      param_cnt_r <= '0;
      id_r        <= '0;
      inst_r      <= '0;
      err_r       <= '0;
      len_lo_r    <= '0;
      crc_lo_r    <= '0;
      ovld_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      crc_r       <= crc_nxt;
      frame_len_r <= frame_len_nxt;
      param_cnt_r <= param_cnt_nxt;
      id_r        <= id_nxt;
      inst_r      <= inst_nxt;
      err_r       <= err_nxt;
      len_lo_r    <= len_lo_nxt;
      crc_lo_r    <= crc_lo_nxt;
      ovld_r      <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_data_r <= o_data_nxt;
    o_id_r   <= o_id_nxt;
    o_inst_r <= o_inst_nxt;
    o_err_r  <= o_err_nxt;
    o_rc_r   <= o_rc_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_ch.valid       = ovld_r;
  assign out_ch.data_byte   = o_data_r;
  assign out_ch.servo_id    = o_id_r;
  assign out_ch.instruction = o_inst_r;
  assign out_ch.error_byte  = o_err_r;
  assign out_ch.result_code = o_rc_r;
  assign out_ch.last        = o_last_r;

endmodule

// ===== hdl/status_packet_deframer_unit.sv =====
// Top level of the status packet deframer: front end, token queue and parser.
//
// in_ch carries one word per handshake: op = 0 with a received byte in
// rx_byte, or op = 1 for a read timeout. out_ch carries parameter bytes
// (last = 0) after the first one, and one verdict word (last = 1) per packet
// with id, instruction, error byte and result code. A receiver drops the
// streamed bytes of a packet whose verdict is not ok.
// Throughput: one input word per cycle while out_ch.ready stays high, set by the
// one-byte CRC update and parser state update in the back end.
// An accepted input word is first written into the queue; the parser step then
// takes it into the output register, where any result word it yields is valid.
// A stalled receiver holds the output register; the parser stops, the
// four-entry queue fills and in_ch.ready drops only once it is full.
// Reset (rst_n low, synchronous) empties the queue and output register and
// puts the parser back to hunting for the first 0xFF.
module status_packet_deframer_unit
  import spd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  spd_in_if.sink     in_ch,
  spd_out_if.source  out_ch
);

  logic push_valid, push_ready;
  tok_t push_tok;
  logic tok_valid, pop;
  tok_t tok;

  spd_front u_front (
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_tok   (push_tok)
  );

  spd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_tok   (push_tok),
    .push_ready (push_ready),
    .pop_valid  (tok_valid),
    .pop_tok    (tok),
    .pop        (pop)
  );

  spd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok       (tok),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/tb_status_packet_deframer_unit.sv =====
// Testbench for status_packet_deframer_unit: directed and random frames against a local model.
module tb_status_packet_deframer_unit;
  import spd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] servo_id;
    logic [7:0] instruction;
    logic [7:0] error_byte;
    rc_t        result_code;
    logic       last;
  } deframe_word_t;

  typedef logic [7:0] byte_q_t [$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spd_in_if  in_ch ();
  spd_out_if out_ch ();

  status_packet_deframer_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  deframe_word_t expected_words [$];
  int  mismatches    = 0;
  int  words_sent    = 0;
  bit  quiet         = 1'b0;
  int  hold_requests = 0;

  // deframer model state
  phase_t      frame_phase;
  logic [15:0] crc_acc;
  logic [15:0] frame_len;
  logic [15:0] param_idx;
  logic [7:0]  pkt_id;
  logic [7:0]  pkt_inst;
  logic [7:0]  pkt_err;
  logic [7:0]  len_lo;
  logic [7:0]  crc_lo;

  // bit-serial CRC-16, poly 0x8005, MSB first
  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic deframer_clear();
    frame_phase = PH_HUNT;
    crc_acc     = '0;
    frame_len   = '0;
    param_idx   = '0;
    pkt_id      = '0;
    pkt_inst    = '0;
    pkt_err     = '0;
    len_lo      = '0;
    crc_lo      = '0;
  endtask

  task automatic emit_verdict(rc_t code);
    deframe_word_t w;
    w             = '0;
    w.servo_id    = pkt_id;
    w.instruction = pkt_inst;
    w.error_byte  = pkt_err;
    w.result_code = code;
    w.last        = 1'b1;
    expected_words = {expected_words, w};
    deframer_clear();
  endtask

  task automatic model_word(bit op, logic [7:0] b);
    deframe_word_t w;
    if (op) begin
      emit_verdict(RC_TIMEOUT);
      return;
    end
    case (frame_phase)
      PH_HDR2: begin
        if (b != HDR_SYNC) begin
          emit_verdict(RC_HEADER);
        end else begin
          crc_acc     = crc16_next(crc_acc, b);
          frame_phase = PH_HDR3;
        end
      end
      PH_HDR3: begin
        if (b != HDR_THIRD) begin
          emit_verdict(RC_HEADER);
        end else begin
          crc_acc     = crc16_next(crc_acc, b);
          frame_phase = PH_HDR4;
        end
      end
      PH_HDR4: begin
        if (b != HDR_FOURTH) begin
          emit_verdict(RC_HEADER);
        end else begin
          crc_acc     = crc16_next(crc_acc, b);
          frame_phase = PH_ID;
        end
      end
      PH_ID: begin
        pkt_id      = b;
        crc_acc     = crc16_next(crc_acc, b);
        frame_phase = PH_LENL;
      end
      PH_LENL: begin
        len_lo      = b;
        crc_acc     = crc16_next(crc_acc, b);
        frame_phase = PH_LENH;
      end
      PH_LENH: begin
        frame_len   = {b, len_lo};
        crc_acc     = crc16_next(crc_acc, b);
        frame_phase = PH_INST;
      end
      PH_INST: begin
        pkt_inst = b;
        crc_acc  = crc16_next(crc_acc, b);
        if (frame_len < LEN_MIN) begin
          emit_verdict(RC_SHORT);
        end else begin
          param_idx = '0;
          if (frame_len == LEN_MIN) frame_phase = PH_CRCL;
          else frame_phase = PH_PARAM;
        end
      end
      PH_PARAM: begin
        crc_acc = crc16_next(crc_acc, b);
        if (param_idx == 16'd0) begin
          pkt_err = b;
        end else begin
          w             = '0;
          w.data_byte   = b;
          w.result_code = RC_OK;
          w.last        = 1'b0;
          expected_words = {expected_words, w};
        end
        param_idx = param_idx + 16'd1;
        if (int'(param_idx) >= int'(frame_len) - 3) frame_phase = PH_CRCL;
      end
      PH_CRCL: begin
        crc_lo      = b;
        frame_phase = PH_CRCH;
      end
      PH_CRCH: begin
        if ({b, crc_lo} == crc_acc) emit_verdict(RC_OK);
        else emit_verdict(RC_CRC);
      end
      default: begin
        if (b == HDR_SYNC) begin
          deframer_clear();
          crc_acc     = crc16_next(16'h0000, b);
          frame_phase = PH_HDR2;
        end else begin
          frame_phase = PH_HUNT;
        end
      end
    endcase
  endtask

  task automatic send_word(bit op, logic [7:0] b);
    while (!quiet && $urandom_range(99) < 37) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.op      = op;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    model_word(op, b);
    words_sent++;
  endtask

  task automatic build_frame(output byte_q_t f, input logic [7:0] id, input logic [7:0] inst,
                             input logic [15:0] len_field, input bit bad_crc);
    logic [15:0] c;
    int          np;
    f = {HDR_SYNC, HDR_SYNC, HDR_THIRD, HDR_FOURTH, id, len_field[7:0], len_field[15:8],
         inst};
    np = (len_field >= LEN_MIN) ? int'(len_field) - 3 : 0;
    repeat (np) f = {f, 8'($urandom_range(255))};
    c = '0;
    foreach (f[i]) c = crc16_next(c, f[i]);
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(15));
    f = {f, c[7:0], c[15:8]};
  endtask

  task automatic send_frame(byte_q_t f, int stop_at, bit end_tmo);
    for (int i = 0; i < stop_at && i < f.size(); i++) send_word(1'b0, f[i]);
    if (end_tmo) send_word(1'b1, 8'($urandom_range(255)));
  endtask

  // receiver: random stalls, optional long hold-off
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = 80;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (quiet) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= 37);
      end
    end
  end

  task automatic check_field(string name, int expv, int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    deframe_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $display({"%0t: unexpected word, expected none, actual data=%0h id=%0h inst=%0h",
                  " err=%0h rc=%0d last=%0b"},
                 $time, out_ch.data_byte, out_ch.servo_id, out_ch.instruction,
                 out_ch.error_byte, out_ch.result_code, out_ch.last);
        mismatches++;
      end else begin
        w = expected_words.pop_front();
        check_field("data_byte", w.data_byte, out_ch.data_byte);
        check_field("servo_id", w.servo_id, out_ch.servo_id);
        check_field("instruction", w.instruction, out_ch.instruction);
        check_field("error_byte", w.error_byte, out_ch.error_byte);
        check_field("result_code", w.result_code, out_ch.result_code);
        check_field("last", w.last, out_ch.last);
      end
    end
  end

  task automatic test_timeouts();
    send_word(1'b1, 8'hFF);
    send_word(1'b0, HDR_SYNC);
    send_word(1'b0, HDR_SYNC);
    send_word(1'b0, HDR_THIRD);
    send_word(1'b0, HDR_FOURTH);
    send_word(1'b0, 8'h3C);
    send_word(1'b1, 8'h00);
  endtask

  task automatic test_header_mismatch();
    send_word(1'b0, HDR_SYNC);
    send_word(1'b0, 8'h00);
    // stray sync in third position must not restart the header
    send_word(1'b0, HDR_SYNC);
    send_word(1'b0, HDR_SYNC);
    send_word(1'b0, HDR_SYNC);
    send_word(1'b0, HDR_SYNC);
    send_word(1'b0, HDR_SYNC);
    send_word(1'b0, HDR_THIRD);
    send_word(1'b0, 8'h01);
  endtask

  task automatic test_short_length();
    byte_q_t f;
    build_frame(f, 8'h00, 8'hFF, 16'd2, 1'b0);
    send_frame(f, 8, 1'b0);
  endtask

  task automatic test_empty_packet();
    byte_q_t f;
    build_frame(f, 8'hFF, 8'h00, 16'd3, 1'b0);
    send_frame(f, f.size(), 1'b0);
  endtask

  task automatic test_backpressure();
    byte_q_t f;
    quiet = 1'b1;
    hold_requests++;
    build_frame(f, 8'h5A, 8'hA5, 16'd27, 1'b0);
    send_frame(f, f.size(), 1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_steady_stream();
    byte_q_t f;
    quiet = 1'b1;
    repeat (15) begin
      build_frame(f, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(8) + 3), 1'b0);
      send_frame(f, f.size(), 1'b0);
    end
    quiet = 1'b0;
  endtask

  task automatic test_long_frame();
    byte_q_t f;
    build_frame(f, 8'h81, 8'h7E, 16'h0100, 1'b0);
    send_frame(f, f.size(), 1'b0);
  endtask

  task automatic test_random_traffic();
    byte_q_t f;
    int      pick;
    int      np;
    int      k;
    while (words_sent < 1200) begin
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) send_word(1'b0, 8'($urandom_range(254)));
      end
      np = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
      build_frame(f, 8'($urandom_range(255)), 8'($urandom_range(255)), 16'(np + 3),
                  pick >= 60 && pick < 72);
      if (pick < 72) begin
        send_frame(f, f.size(), 1'b0);
      end else if (pick < 82) begin
        send_frame(f, $urandom_range(f.size() - 1, 1), 1'b1);
      end else if (pick < 88) begin
        k    = $urandom_range(3, 1);
        f[k] = f[k] ^ 8'($urandom_range(255, 1));
        send_frame(f, k + 1, 1'b0);
      end else if (pick < 93) begin
        build_frame(f, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    16'($urandom_range(2)), 1'b0);
        send_frame(f, 8, 1'b0);
      end else begin
        repeat ($urandom_range(6, 1)) send_word(1'b0, 8'($urandom_range(255)));
        send_word(1'b1, 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.op      = 1'b0;
    in_ch.rx_byte = 8'h00;
    deframer_clear();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_timeouts();
    test_header_mismatch();
    test_short_length();
    test_empty_packet();
    test_backpressure();
    test_steady_stream();
    test_long_frame();
    test_random_traffic();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
    end
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/spd_pkg.sv
hdl/spd_if.sv
hdl/spd_front.sv
hdl/spd_queue.sv
hdl/spd_back.sv
hdl/status_packet_deframer_unit.sv
tb/tb_status_packet_deframer_unit.sv
